// ----- rtl/core/grid_cell_corner_bucketing_core_defines.svh -----
`ifndef GRID_CELL_CORNER_BUCKETING_CORE_DEFINES_SVH
`define GRID_CELL_CORNER_BUCKETING_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gcb_pkg.sv -----
package gcb_pkg;

  localparam int COORD_BITS         = 12;
  localparam int DEF_MAX_GRID_CELLS = 1024;

  localparam int KIND_W  = 2;
  localparam int LVL_W   = 3;
  localparam int CS_W    = 8;
  localparam int DIM_W   = 13;
  localparam int NLVL_W  = 4;
  localparam int SCORE_W = 32;
  localparam int STAT_W  = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int DIV_W   = DIM_W + 1;
  localparam int SHIFT_W = COORD_BITS + (1 << LVL_W) - 1;
  localparam int PROD_W  = 2 * DIV_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ENTRY_W = SCORE_W + 2;

  localparam logic [CS_W-1:0]    RST_CELL_SIZE = 8'd32;
  localparam logic [DIM_W-1:0]   RST_WIDTH     = 13'd640;
  localparam logic [DIM_W-1:0]   RST_HEIGHT    = 13'd480;
  localparam logic [NLVL_W-1:0]  RST_LEVELS    = 4'd3;
  localparam logic [SCORE_W-1:0] RST_THRESHOLD = 32'd1310720;

  typedef enum logic [KIND_W-1:0] {
    KIND_CORNER = 2'd0,
    KIND_MARK   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FEATURE    = 3'd0,
    ST_BOUNDS     = 3'd1,
    ST_OCCUPIED   = 3'd2,
    ST_NOT_BETTER = 3'd3,
    ST_CAPACITY   = 3'd4,
    ST_MARKED     = 3'd5,
    ST_CLEARED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_CELL_SIZE = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_LEVELS    = 3'd3,
    REG_THRESHOLD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic    load_in;
    logic    div_start;
    logic    div_grid;
    logic    grid_load;
    logic    mul_en;
    logic    idx_rd;
    logic    decide;
    logic    clr_en;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_corner;
    logic is_mark;
    logic is_clear;
    logic corner_oob;
    logic mark_oob;
    logic over_cap;
    logic div_busy;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/gcb_div.sv -----
module gcb_div
  import gcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CS_W-1:0]  divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] num_r;
  logic [CS_W-1:0]  rem_r;
  logic [CS_W-1:0]  dvs_r;

  logic [CS_W:0]    trial;
  logic [CS_W:0]    diff;
  logic             ge;
  logic [CS_W-1:0]  rem_nxt;
  logic [DIV_W-1:0] num_nxt;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial   = {rem_r, num_r[DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[CS_W-1:0] : trial[CS_W-1:0];
    num_nxt = {num_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = num_r;

endmodule

// ----- rtl/core/gcb_ctrl.sv -----
module gcb_ctrl
  import gcb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_FLUSH    = 9'b000001000,
    S_GRID     = 9'b000010000,
    S_CELL     = 9'b000100000,
    S_INDEX    = 9'b001000000,
    S_DECIDE   = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_clear) begin
          state_nxt = S_FLUSH;
        end else if (!(stat.is_corner || stat.is_mark) ||
                     (stat.is_corner && stat.corner_oob)) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BOUNDS;
          state_nxt    = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_grid  = 1'b1;
          state_nxt     = S_GRID;
        end
      end
      S_FLUSH: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_CLEARED;
          state_nxt    = S_FINISH;
        end
      end
      S_GRID: begin
        if (!stat.div_busy) begin
          cmd.grid_load = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_CELL;
        end
      end
      S_CELL: begin
        if (!stat.div_busy) begin
          if (stat.is_mark && stat.mark_oob) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_BOUNDS;
            state_nxt    = S_FINISH;
          end else begin
            cmd.mul_en = 1'b1;
            state_nxt  = S_INDEX;
          end
        end
      end
      S_INDEX: begin
        if (stat.over_cap) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_CAPACITY;
          state_nxt    = S_FINISH;
        end else begin
          cmd.idx_rd = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ----- rtl/core/gcb_datapath.sv -----
module gcb_datapath
  import gcb_pkg::*;
#(
  parameter int MAX_GRID_CELLS = DEF_MAX_GRID_CELLS,
  parameter int IDX_W          = $clog2(MAX_GRID_CELLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [CS_W-1:0]       cell_side,
  input  logic [DIM_W-1:0]      image_width,
  input  logic [DIM_W-1:0]      image_height,
  input  logic [NLVL_W-1:0]     pyramid_levels,
  input  logic [SCORE_W-1:0]    score_floor,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [LVL_W-1:0]      in_level,
  input  logic [SCORE_W-1:0]    in_score,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_W-1:0]     out_status,
  output logic [COORD_BITS-1:0] out_feature_x,
  output logic [COORD_BITS-1:0] out_feature_y,
  output logic [LVL_W-1:0]      out_feature_level,
  output logic [SCORE_W-1:0]    out_feature_score,
  output logic [IDX_W-1:0]      out_cell_index
);

  localparam logic [SUM_W-1:0] IDX_LIM  = SUM_W'(MAX_GRID_CELLS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_GRID_CELLS - 1);

  logic [KIND_W-1:0]     kind_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [LVL_W-1:0]      lvl_r;
  logic [SCORE_W-1:0]    score_r;

  logic [DIV_W-1:0]      cols_r;
  logic [DIV_W-1:0]      rows_r;
  logic [PROD_W-1:0]     prod_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ENTRY_W-1:0]    rd_r;
  logic [IDX_W-1:0]      clr_cnt_r;

  logic [ENTRY_W-1:0]    mem [MAX_GRID_CELLS];

  logic [STAT_W-1:0]     res_status_r;
  logic [COORD_BITS-1:0] res_fx_r;
  logic [COORD_BITS-1:0] res_fy_r;
  logic [LVL_W-1:0]      res_flvl_r;
  logic [SCORE_W-1:0]    res_fscore_r;
  logic [IDX_W-1:0]      res_cidx_r;

  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [COORD_BITS-1:0] out_fx_r;
  logic [COORD_BITS-1:0] out_fy_r;
  logic [LVL_W-1:0]      out_flvl_r;
  logic [SCORE_W-1:0]    out_fscore_r;
  logic [IDX_W-1:0]      out_cidx_r;

  logic [CS_W-1:0]       cs_eff;
  logic [DIM_W-1:0]      w_lvl;
  logic [DIM_W-1:0]      h_lvl;
  logic [SHIFT_W-1:0]    sx_full;
  logic [SHIFT_W-1:0]    sy_full;
  logic [DIV_W-1:0]      div_x;
  logic [DIV_W-1:0]      div_y;
  logic [DIV_W-1:0]      qx;
  logic [DIV_W-1:0]      qy;
  logic                  busy_x;
  logic                  busy_y;
  logic [SUM_W-1:0]      sum;
  logic                  occ;
  logic                  best_valid;
  logic [SCORE_W-1:0]    best;
  logic                  wr_en;
  logic [ENTRY_W-1:0]    wr_data;
  status_t               dec_status;

  always_comb begin
    cs_eff  = (cell_side == '0) ? CS_W'(1) : cell_side;
    w_lvl   = image_width >> lvl_r;
    h_lvl   = image_height >> lvl_r;
    sx_full = SHIFT_W'(px_r) << lvl_r;
    sy_full = SHIFT_W'(py_r) << lvl_r;
    if (cmd.div_grid) begin
      div_x = DIV_W'(image_width) + DIV_W'(cs_eff) - DIV_W'(1);
      div_y = DIV_W'(image_height) + DIV_W'(cs_eff) - DIV_W'(1);
    end else if (kind_r == KIND_CORNER) begin
      div_x = sx_full[DIV_W-1:0];
      div_y = sy_full[DIV_W-1:0];
    end else begin
      div_x = DIV_W'(px_r);
      div_y = DIV_W'(py_r);
    end
    sum = SUM_W'(prod_r) + SUM_W'(qx);
  end

  gcb_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_x),
    .divisor  (cs_eff),
    .busy     (busy_x),
    .quotient (qx)
  );

  gcb_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_y),
    .divisor  (cs_eff),
    .busy     (busy_y),
    .quotient (qy)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= in_kind;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      lvl_r   <= in_level;
      score_r <= in_score;
    end
    if (cmd.grid_load) begin
      cols_r <= qx;
      rows_r <= qy;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(qy) * PROD_W'(cols_r);
    end
  end

  // Cell table: occupied bit, best-valid bit and best score in one word.
  always_ff @(posedge clk) begin
    if (cmd.idx_rd) begin
      idx_r <= sum[IDX_W-1:0];
      rd_r  <= mem[sum[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= (clr_cnt_r == IDX_LAST) ? '0 : clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    occ        = rd_r[ENTRY_W-1];
    best_valid = rd_r[ENTRY_W-2];
    best       = best_valid ? rd_r[SCORE_W-1:0] : score_floor;
    wr_en      = 1'b0;
    wr_data    = rd_r;
    if (kind_r == KIND_MARK) begin
      dec_status = ST_MARKED;
      wr_en      = cmd.decide;
      wr_data    = {1'b1, best_valid, rd_r[SCORE_W-1:0]};
    end else if (occ) begin
      dec_status = ST_OCCUPIED;
    end else if (score_r > best) begin
      dec_status = ST_FEATURE;
      wr_en      = cmd.decide;
      wr_data    = {1'b0, 1'b1, score_r};
    end else begin
      dec_status = ST_NOT_BETTER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_fx_r     <= '0;
      res_fy_r     <= '0;
      res_flvl_r   <= '0;
      res_fscore_r <= '0;
      res_cidx_r   <= '0;
    end else if (cmd.decide) begin
      res_status_r <= dec_status;
      res_cidx_r   <= idx_r;
      if (dec_status == ST_FEATURE) begin
        res_fx_r     <= sx_full[COORD_BITS-1:0];
        res_fy_r     <= sy_full[COORD_BITS-1:0];
        res_flvl_r   <= lvl_r;
        res_fscore_r <= score_r;
      end else begin
        res_fx_r     <= '0;
        res_fy_r     <= '0;
        res_flvl_r   <= '0;
        res_fscore_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_fx_r     <= res_fx_r;
      out_fy_r     <= res_fy_r;
      out_flvl_r   <= res_flvl_r;
      out_fscore_r <= res_fscore_r;
      out_cidx_r   <= res_cidx_r;
    end
  end

  always_comb begin
    stat.is_corner  = (kind_r == KIND_CORNER);
    stat.is_mark    = (kind_r == KIND_MARK);
    stat.is_clear   = (kind_r == KIND_CLEAR);
    stat.corner_oob = ({1'b0, lvl_r} >= pyramid_levels) ||
                      (DIM_W'(px_r) >= w_lvl) || (DIM_W'(py_r) >= h_lvl);
    stat.mark_oob   = (qx >= cols_r) || (qy >= rows_r);
    stat.over_cap   = (sum >= IDX_LIM);
    stat.div_busy   = busy_x || busy_y;
    stat.clr_last   = (clr_cnt_r == IDX_LAST);
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_feature_x     = out_fx_r;
  assign out_feature_y     = out_fy_r;
  assign out_feature_level = out_flvl_r;
  assign out_feature_score = out_fscore_r;
  assign out_cell_index    = out_cidx_r;

endmodule

// ----- rtl/core/grid_cell_corner_bucketing_core.sv -----
// Channel  Direction  Handshake          Word
// in       input      in_valid/in_ready  kind, pos_x, pos_y, level, score
// out      output     out_valid/out_ready status, feature x/y/level/score, cell index
// cfg      input      APB psel/penable   five registers at byte offsets 0 to 16
//
// A corner or mark word inside the grid makes two passes through a 14-step shift-subtract
// divider (grid size, then cell coordinates); rejected words end sooner.
// An end-of-frame word clears the cell table, one table entry cleared per cycle.
// After reset the cell table is cleared before in_ready rises.
// One word is processed at a time; a waiting result holds only the final write of the next.
module grid_cell_corner_bucketing_core
  import gcb_pkg::*;
#(
  parameter int MAX_GRID_CELLS = DEF_MAX_GRID_CELLS,
  parameter int IDX_W          = $clog2(MAX_GRID_CELLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [LVL_W-1:0]      in_level,
  input  logic [SCORE_W-1:0]    in_score,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_W-1:0]     out_status,
  output logic [COORD_BITS-1:0] out_feature_x,
  output logic [COORD_BITS-1:0] out_feature_y,
  output logic [LVL_W-1:0]      out_feature_level,
  output logic [SCORE_W-1:0]    out_feature_score,
  output logic [IDX_W-1:0]      out_cell_index,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  `include "grid_cell_corner_bucketing_core_defines.svh"

  logic [CS_W-1:0]    cell_side_r;
  logic [DIM_W-1:0]   image_width_r;
  logic [DIM_W-1:0]   image_height_r;
  logic [NLVL_W-1:0]  pyramid_levels_r;
  logic [SCORE_W-1:0] threshold_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_side_r      <= RST_CELL_SIZE;
      image_width_r    <= RST_WIDTH;
      image_height_r   <= RST_HEIGHT;
      pyramid_levels_r <= RST_LEVELS;
      threshold_r      <= RST_THRESHOLD;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CELL_SIZE: cell_side_r      <= pwdata[CS_W-1:0];
        REG_WIDTH:     image_width_r    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:    image_height_r   <= pwdata[DIM_W-1:0];
        REG_LEVELS:    pyramid_levels_r <= pwdata[NLVL_W-1:0];
        REG_THRESHOLD: threshold_r      <= pwdata[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CELL_SIZE: prdata = DATA_W'(cell_side_r);
      REG_WIDTH:     prdata = DATA_W'(image_width_r);
      REG_HEIGHT:    prdata = DATA_W'(image_height_r);
      REG_LEVELS:    prdata = DATA_W'(pyramid_levels_r);
      REG_THRESHOLD: prdata = DATA_W'(threshold_r);
      default:       prdata = '0;
    endcase
  end

  gcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcb_datapath #(
    .MAX_GRID_CELLS (MAX_GRID_CELLS),
    .IDX_W          (IDX_W)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cell_side           (cell_side_r),
    .image_width         (image_width_r),
    .image_height        (image_height_r),
    .pyramid_levels      (pyramid_levels_r),
    .score_floor         (threshold_r),
    .in_kind             (in_kind),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_level            (in_level),
    .in_score            (in_score),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_feature_x       (out_feature_x),
    .out_feature_y       (out_feature_y),
    .out_feature_level   (out_feature_level),
    .out_feature_score   (out_feature_score),
    .out_cell_index      (out_cell_index)
  );

  `GCB_ASSERT_NEXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken while busy")
  `GCB_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, stat.out_free, "waiting result overwritten")
  `GCB_ASSERT_NOW(a_clear_idle, clk, rst_n, cmd.clr_en, !in_ready, "word taken during table clear")
  `GCB_ASSERT_NOW(a_cmd_excl, clk, rst_n, 1'b1, $onehot0({cmd.div_start, cmd.idx_rd, cmd.decide, cmd.clr_en}), "conflicting datapath commands")

endmodule
